FILE: rtl/wgns_pkg.sv
// Shared constants and types for the wall grid smoothing core.
package wgns_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SIZE_W     = 9;
	localparam int THR_W      = 4;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SIZE_W;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	localparam logic [SIZE_W-1:0] MIN_SIZE    = SIZE_W'(3);
	localparam logic [SIZE_W-1:0] RST_WIDTH   = SIZE_W'(64);
	localparam logic [SIZE_W-1:0] RST_HEIGHT  = SIZE_W'(64);
	localparam logic [THR_W-1:0]  RST_KEEP    = THR_W'(5);
	localparam logic [THR_W-1:0]  RST_GROW    = THR_W'(6);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_WALL_KEEP   = 2'd2,
		REG_FLOOR_GROW  = 2'd3
	} cfg_reg_t;

	// One result cell as held in an output slot.
	typedef struct packed {
		logic [COL_W-1:0] cell_col;
		logic [ROW_W-1:0] cell_row;
		logic             result_is_wall;
		logic             was_smoothed;
		logic             run_last;
		logic             frame_last;
	} result_t;

endpackage

FILE: rtl/wgns_line_buf.sv
// Two-row line buffer: one 1-bit memory bank per row parity, read-old on write.
module wgns_line_buf (
	input  logic                      clk,
	input  logic                      en,
	input  logic [wgns_pkg::COL_W-1:0] addr,
	input  logic                      wr_bank,
	input  logic                      wr_data,
	output logic                      bank0_q,
	output logic                      bank1_q
);

	logic mem0 [wgns_pkg::MAX_WIDTH];
	logic mem1 [wgns_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (en) begin
			bank0_q <= mem0[addr];
			if (!wr_bank) begin
				mem0[addr] <= wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bank1_q <= mem1[addr];
			if (wr_bank) begin
				mem1[addr] <= wr_data;
			end
		end
	end

endmodule

FILE: rtl/wall_grid_neighbor_smoothing_core.sv
// Top level: one-pass cave smoothing with configurable keep/grow thresholds over a raster stream of wall/floor cells.
//
//  channel   | direction | contents
//  ----------+-----------+------------------------------------------------------
//  s_axis    | in        | tdata[0] cell_is_wall, raster order
//  m_axis    | out       | tdata col/row/result_is_wall, tuser kind, tlast frame end
//  cfg       | in        | cfg_we / cfg_index / cfg_wdata register writes
//
// Flow: a request is registered into s1 (line buffer read, border flags) when
// accepted, then moves into two output slots once they are free. A request yields
// 0, 1 or 2 results; the slots drain one per cycle while m_axis_tready is high, so
// the input runs at one request per cycle but for stalls and two-result edge cells.
// Reset clears counters, window and valids; line buffer contents are not cleared
// (unwritten entries only ever feed neighbours that are forced to wall).
// Output stall backs up through the slots into s1 and then s_axis_tready.
module wall_grid_neighbor_smoothing_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [wgns_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [0] cell_is_wall
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [wgns_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [7:0] cell_col,
	                                                           // [15:8] cell_row,
	                                                           // [16] result_is_wall
	output logic [wgns_pkg::OUT_USER_W-1:0]     m_axis_tuser,  // [0] was_smoothed,
	                                                           // [1] run_last
	output logic                                m_axis_tlast,  // frame_last
	// configuration
	input  logic                                cfg_we,
	input  logic [wgns_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wgns_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int COL_W = wgns_pkg::COL_W;
	localparam int ROW_W = wgns_pkg::ROW_W;

	// ---------------- configuration registers ----------------
	logic [wgns_pkg::SIZE_W-1:0] width_q, height_q;
	logic [wgns_pkg::THR_W-1:0]  keep_thr_q, grow_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= wgns_pkg::RST_WIDTH;
			height_q   <= wgns_pkg::RST_HEIGHT;
			keep_thr_q <= wgns_pkg::RST_KEEP;
			grow_thr_q <= wgns_pkg::RST_GROW;
		end else if (cfg_we) begin
			case (wgns_pkg::cfg_reg_t'(cfg_index))
				wgns_pkg::REG_GRID_WIDTH:  width_q    <= cfg_wdata;
				wgns_pkg::REG_GRID_HEIGHT: height_q   <= cfg_wdata;
				wgns_pkg::REG_WALL_KEEP:   keep_thr_q <= cfg_wdata[wgns_pkg::THR_W-1:0];
				wgns_pkg::REG_FLOOR_GROW:  grow_thr_q <= cfg_wdata[wgns_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// last index after saturating the size into 3..MAX
	logic [COL_W-1:0] wm1;
	logic [ROW_W-1:0] hm1;

	always_comb begin
		if (width_q < wgns_pkg::MIN_SIZE)
			wm1 = COL_W'(wgns_pkg::MIN_SIZE - 1'b1);
		else if (width_q > wgns_pkg::SIZE_W'(wgns_pkg::MAX_WIDTH))
			wm1 = COL_W'(wgns_pkg::MAX_WIDTH - 1);
		else
			wm1 = COL_W'(width_q - 1'b1);
		if (height_q < wgns_pkg::MIN_SIZE)
			hm1 = ROW_W'(wgns_pkg::MIN_SIZE - 1'b1);
		else if (height_q > wgns_pkg::SIZE_W'(wgns_pkg::MAX_HEIGHT))
			hm1 = ROW_W'(wgns_pkg::MAX_HEIGHT - 1);
		else
			hm1 = ROW_W'(height_q - 1'b1);
	end

	// ---------------- handshake control ----------------
	logic s1_v_q, a_v_q, b_v_q;
	logic in_acc, s1_adv, slots_free, out_pop;

	assign out_pop       = m_axis_tvalid && m_axis_tready;
	// slots are free next cycle if empty, or a single result leaves now
	assign slots_free    = !(a_v_q || b_v_q) || (m_axis_tready && (a_v_q != b_v_q));
	assign s1_adv        = s1_v_q && slots_free;
	assign s_axis_tready = !s1_v_q || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// ---------------- raster position ----------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_col, last_row;

	assign last_col = col_q >= wm1;
	assign last_row = row_q >= hm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// neighbour rows/columns that count as wall, index 0 = minus one, 2 = plus one
	logic [2:0] row_force, col_force;

	always_comb begin
		row_force[2] = last_row;
		row_force[1] = row_q > hm1;
		row_force[0] = (row_q < ROW_W'(2)) ||
		               ({1'b0, row_q} > ({1'b0, hm1} + (ROW_W+1)'(1)));
		col_force[2] = last_col;
		col_force[1] = col_q > wm1;
		col_force[0] = (col_q < COL_W'(2)) ||
		               ({1'b0, col_q} > ({1'b0, wm1} + (COL_W+1)'(1)));
	end

	// ---------------- line buffer ----------------
	logic bank0_rd, bank1_rd;

	wgns_line_buf u_line_buf (
		.clk     (clk),
		.en      (in_acc),
		.addr    (col_q),
		.wr_bank (row_q[0]),
		.wr_data (s_axis_tdata[0]),
		.bank0_q (bank0_rd),
		.bank1_q (bank1_rd)
	);

	// ---------------- stage 1 ----------------
	logic             cell_s1, par_s1, emit_a_s1, emit_b_s1, frame_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [2:0]       row_force_s1, col_force_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_v_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cell_s1      <= s_axis_tdata[0];
			par_s1       <= row_q[0];
			col_s1       <= col_q;
			row_s1       <= row_q;
			row_force_s1 <= row_force;
			col_force_s1 <= col_force;
			emit_a_s1    <= (row_q != '0) && (col_q != '0);
			emit_b_s1    <= last_col || last_row;
			frame_s1     <= last_col && last_row;
		end
	end

	// 3x3 window of original cells, bit row*3+col, row 2 / col 2 newest
	logic [8:0] win_q, win_nxt;
	logic       top_bit, mid_bit;

	assign top_bit = par_s1 ? bank1_rd : bank0_rd;
	assign mid_bit = par_s1 ? bank0_rd : bank1_rd;
	assign win_nxt = ((win_q >> 1) & 9'h0DB) | {cell_s1, 2'b00, mid_bit, 2'b00, top_bit, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= win_nxt;
		end
	end

	// wall count over the 8 neighbours of the window centre
	logic [wgns_pkg::CNT_W-1:0] wall_cnt;
	logic                       smooth_wall;

	always_comb begin
		wall_cnt = '0;
		for (int dy = 0; dy < 3; dy++) begin
			for (int dx = 0; dx < 3; dx++) begin
				if (!(dy == 1 && dx == 1)) begin
					wall_cnt = wall_cnt + wgns_pkg::CNT_W'(row_force_s1[dy] ||
					           col_force_s1[dx] || win_nxt[dy*3 + dx]);
				end
			end
		end
		smooth_wall = win_nxt[4] ? (wall_cnt >= keep_thr_q) : (wall_cnt >= grow_thr_q);
	end

	// ---------------- output slots: a = smoothed, b = pass-through ----------------
	wgns_pkg::result_t a_q, b_q, res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q <= 1'b0;
			b_v_q <= 1'b0;
		end else if (s1_adv) begin
			a_v_q <= emit_a_s1;
			b_v_q <= emit_b_s1;
		end else if (out_pop) begin
			if (a_v_q)
				a_v_q <= 1'b0;
			else
				b_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			a_q.cell_col       <= col_s1 - 1'b1;
			a_q.cell_row       <= row_s1 - 1'b1;
			a_q.result_is_wall <= smooth_wall;
			a_q.was_smoothed   <= 1'b1;
			a_q.run_last       <= !emit_b_s1;
			a_q.frame_last     <= 1'b0;
			b_q.cell_col       <= col_s1;
			b_q.cell_row       <= row_s1;
			b_q.result_is_wall <= cell_s1;
			b_q.was_smoothed   <= 1'b0;
			b_q.run_last       <= 1'b1;
			b_q.frame_last     <= frame_s1;
		end
	end

	assign res_out       = a_v_q ? a_q : b_q;
	assign m_axis_tvalid = a_v_q || b_v_q;
	assign m_axis_tdata  = {7'd0, res_out.result_is_wall, res_out.cell_row, res_out.cell_col};
	assign m_axis_tuser  = {res_out.run_last, res_out.was_smoothed};
	assign m_axis_tlast  = res_out.frame_last;

	// ---------------- assertions ----------------
	// grid end request sends the raster position back to the origin
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_col && last_row |=> col_q == '0 && row_q == '0)
		else $error("raster position did not wrap after grid end");

	// frame end is only ever flagged on a pass-through that closes its run
	a_frame_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1] && !m_axis_tuser[0])
		else $error("frame_last on a result that is not a final pass-through");

	// with both slots full, the pass-through still waits after the smoothed one leaves
	a_pair_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_pop && a_v_q && b_v_q |=> m_axis_tvalid && !m_axis_tuser[0])
		else $error("pass-through result lost after smoothed result");

endmodule

FILE: tb/wall_grid_neighbor_smoothing_core_test.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the wall grid neighbor smoothing core.
module wall_grid_neighbor_smoothing_core_test;

	localparam int  CLK_HALF_NS = 4;
	localparam int  RESET_CYCLES = 9;
	localparam int  SETTLE_CYCLES = 8;     // margin after the block goes idle
	localparam int  RANDOM_CELLS = 12;
	localparam int  REPORT_LIMIT = 10;
	// ~200 cells at most, each with the longest gap plus two results each behind the
	// longest stall, taken about five times over
	localparam longint TIMEOUT_NS = 64'd2_000_000;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [wgns_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [wgns_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
	logic [wgns_pkg::OUT_USER_W-1:0]     m_axis_tuser;
	logic                                m_axis_tlast;
	logic                                cfg_we = 1'b0;
	logic [wgns_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [wgns_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

	wall_grid_neighbor_smoothing_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [0] cell_is_wall
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [7:0] cell_col, [15:8] cell_row, [16] result_is_wall
		.m_axis_tuser  (m_axis_tuser),   // [0] was_smoothed, [1] run_last
		.m_axis_tlast  (m_axis_tlast),   // frame_last
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// ---------------------------------------------------------------------------------------
	// Predictor: its own copy of the registers, the two-row line store, the 3x3 window of
	// original cells and the raster counters.
	// ---------------------------------------------------------------------------------------
	logic [wgns_pkg::SIZE_W-1:0] cfg_width = wgns_pkg::RST_WIDTH;
	logic [wgns_pkg::SIZE_W-1:0] cfg_height = wgns_pkg::RST_HEIGHT;
	logic [wgns_pkg::THR_W-1:0]  cfg_keep = wgns_pkg::RST_KEEP;
	logic [wgns_pkg::THR_W-1:0]  cfg_grow = wgns_pkg::RST_GROW;

	logic                        cave_line [0:2*wgns_pkg::MAX_WIDTH-1];
	logic [8:0]                  cave_window = '0;
	logic [wgns_pkg::COL_W-1:0]  scan_col = '0;
	logic [wgns_pkg::ROW_W-1:0]  scan_row = '0;

	wgns_pkg::result_t           expected_cells [$];
	logic                        cell_queue [$];      // cells waiting to be sent
	int                          cells_in_flight = 0; // queued or on the bus, not yet accepted
	bit                          in_taken = 1'b0;     // request accepted at the last rising edge

	bit                calm_phase = 1'b0;   // no gaps and no stalls while set
	int                send_gap = 0;
	int                recv_stall = 0;
	int                mismatches = 0;
	int                results_seen = 0;
	int                cells_sent = 0;
	int                phases_run = 0;

	initial begin
		for (int i = 0; i < 2 * wgns_pkg::MAX_WIDTH; i++)
			cave_line[i] = 1'b0;
	end

	function automatic logic [wgns_pkg::SIZE_W-1:0] clamp_size(
		input logic [wgns_pkg::SIZE_W-1:0] v, input int hi);
		if (v < wgns_pkg::MIN_SIZE)
			return wgns_pkg::MIN_SIZE;
		if (v > wgns_pkg::SIZE_W'(hi))
			return wgns_pkg::SIZE_W'(hi);
		return v;
	endfunction

	// Cells still needed from the current counters to the frame end.
	function automatic int cells_to_frame_end();
		int w, h, left;
		w = int'(clamp_size(cfg_width, wgns_pkg::MAX_WIDTH));
		h = int'(clamp_size(cfg_height, wgns_pkg::MAX_HEIGHT));
		left = (int'(scan_col) >= w - 1) ? 1 : w - int'(scan_col);
		if (int'(scan_row) < h - 1)
			left += (h - 1 - int'(scan_row)) * w;
		return left;
	endfunction

	// Runs one accepted cell through the smoothing rule and queues what it causes.
	task automatic smooth_predict(input logic cell_bit);
		logic [wgns_pkg::SIZE_W-1:0] w, h;
		logic                        top, mid, verdict, last_col, last_row;
		logic [wgns_pkg::CNT_W-1:0]  walls;
		int                          nr, nc, n, dy, dx;
		wgns_pkg::result_t           res [2];
		w = clamp_size(cfg_width, wgns_pkg::MAX_WIDTH);
		h = clamp_size(cfg_height, wgns_pkg::MAX_HEIGHT);
		last_col = {1'b0, scan_col} >= w - 9'd1;
		last_row = {1'b0, scan_row} >= h - 9'd1;
		top = cave_line[{scan_row[0], scan_col}];
		mid = cave_line[{~scan_row[0], scan_col}];
		cave_line[{scan_row[0], scan_col}] = cell_bit;
		// bit row*3+col, row 0 = R-2 .. row 2 = R, col 0 = C-2 .. col 2 = C
		cave_window = ((cave_window >> 1) & 9'h0DB) | {6'b0, top, 2'b0} |
			{3'b0, mid, 5'b0} | {cell_bit, 8'b0};
		n = 0;
		if (scan_row >= 1 && scan_col >= 1) begin
			walls = '0;
			for (dy = -1; dy <= 1; dy++) begin
				for (dx = -1; dx <= 1; dx++) begin
					if (dy == 0 && dx == 0)
						continue;
					nr = int'(scan_row) - 1 + dy;
					nc = int'(scan_col) - 1 + dx;
					// off-grid and border neighbors count as wall
					if (nr < 0 || nc < 0 || nr >= int'(h) - 1 || nc >= int'(w) - 1)
						walls = walls + 4'd1;
					else
						walls = walls + wgns_pkg::CNT_W'(cave_window[(dy + 1) * 3 + (dx + 1)]);
				end
			end
			verdict = cave_window[4] ? (walls >= cfg_keep) : (walls >= cfg_grow);
			res[n] = '{cell_col: scan_col - 1'b1, cell_row: scan_row - 1'b1,
				result_is_wall: verdict, was_smoothed: 1'b1, run_last: 1'b0,
				frame_last: 1'b0};
			n++;
		end
		if (last_col || last_row) begin
			res[n] = '{cell_col: scan_col, cell_row: scan_row, result_is_wall: cell_bit,
				was_smoothed: 1'b0, run_last: 1'b0, frame_last: last_col && last_row};
			n++;
		end
		if (n > 0)
			res[n - 1].run_last = 1'b1;
		for (int k = 0; k < n; k++)
			expected_cells.insert(expected_cells.size(), res[k]);
		if (last_col) begin
			scan_col = '0;
			scan_row = last_row ? '0 : scan_row + 1'b1;
		end else begin
			scan_col = scan_col + 1'b1;
		end
	endtask

	// Mostly back to back, some short gaps, a few long ones.
	function automatic int draw_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (calm_phase)
			return 0;
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ---------------------------------------------------------------------------------------
	// Monitor: checks each accepted result against the oldest expectation, then feeds each
	// accepted request into the predictor.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		wgns_pkg::result_t got, want;
		in_taken = s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got = '{cell_col: m_axis_tdata[7:0], cell_row: m_axis_tdata[15:8],
					result_is_wall: m_axis_tdata[16], was_smoothed: m_axis_tuser[0],
					run_last: m_axis_tuser[1], frame_last: m_axis_tlast};
				if (expected_cells.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected: col %0d row %0d wall %0b sm %0b rl %0b fl %0b",
							got.cell_col, got.cell_row, got.result_is_wall,
							got.was_smoothed, got.run_last, got.frame_last);
				end else begin
					want = expected_cells.pop_front();
					if (got.cell_col !== want.cell_col || got.cell_row !== want.cell_row ||
						got.result_is_wall !== want.result_is_wall ||
						got.was_smoothed !== want.was_smoothed ||
						got.run_last !== want.run_last ||
						got.frame_last !== want.frame_last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("mismatch: exp col %0d row %0d wall %0b sm %0b rl %0b fl %0b",
								want.cell_col, want.cell_row, want.result_is_wall,
								want.was_smoothed, want.run_last, want.frame_last);
							$display("          got col %0d row %0d wall %0b sm %0b rl %0b fl %0b",
								got.cell_col, got.cell_row, got.result_is_wall,
								got.was_smoothed, got.run_last, got.frame_last);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				smooth_predict(s_axis_tdata[0]);
				cells_in_flight--;
				cells_sent++;
			end
		end
	end

	// Driver: holds a request until accepted, then waits its gap and sends the next one.
	always @(negedge clk) begin
		logic                           next_valid;
		logic [wgns_pkg::IN_DATA_W-1:0] next_data;
		next_valid = s_axis_tvalid;
		next_data = s_axis_tdata;
		if (in_taken)
			next_valid = 1'b0;   // taken at the edge just passed
		if (!next_valid) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (cell_queue.size() > 0) begin
				next_data = {{(wgns_pkg::IN_DATA_W-1){1'b0}}, cell_queue.pop_front()};
				next_valid = 1'b1;
				send_gap = draw_gap();
			end
		end
		s_axis_tvalid <= next_valid;
		s_axis_tdata <= next_data;
	end

	// Receiver: random stalls, independent of whether a result is waiting.
	always @(negedge clk) begin
		logic next_ready;
		if (recv_stall > 0) begin
			recv_stall--;
			next_ready = 1'b0;
		end else begin
			next_ready = 1'b1;
			if ($urandom_range(0, 99) < 30)
				recv_stall = draw_gap();
		end
		m_axis_tready <= next_ready;
	end

	// ---------------------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------------------
	task automatic write_reg(input wgns_pkg::cfg_reg_t idx,
		input logic [wgns_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			wgns_pkg::REG_GRID_WIDTH:  cfg_width = value;
			wgns_pkg::REG_GRID_HEIGHT: cfg_height = value;
			wgns_pkg::REG_WALL_KEEP:   cfg_keep = value[wgns_pkg::THR_W-1:0];
			wgns_pkg::REG_FLOOR_GROW:  cfg_grow = value[wgns_pkg::THR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Block idle: every request accepted, every result in, then a settling wait.
	task automatic wait_idle();
		while (cells_in_flight != 0 || expected_cells.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes all four registers, then queues cells; a negative count runs to the frame end.
	task automatic run_phase(input logic [wgns_pkg::SIZE_W-1:0] w_raw,
		input logic [wgns_pkg::SIZE_W-1:0] h_raw,
		input logic [wgns_pkg::THR_W-1:0] keep, input logic [wgns_pkg::THR_W-1:0] grow,
		input int density, input int count, input bit calm);
		int n;
		wait_idle();
		calm_phase = calm;
		write_reg(wgns_pkg::REG_GRID_WIDTH, w_raw);
		write_reg(wgns_pkg::REG_GRID_HEIGHT, h_raw);
		write_reg(wgns_pkg::REG_WALL_KEEP,
			{{(wgns_pkg::CFG_DATA_W-wgns_pkg::THR_W){1'b0}}, keep});
		write_reg(wgns_pkg::REG_FLOOR_GROW,
			{{(wgns_pkg::CFG_DATA_W-wgns_pkg::THR_W){1'b0}}, grow});
		n = (count < 0) ? cells_to_frame_end() : count;
		for (int i = 0; i < n; i++)
			cell_queue.insert(cell_queue.size(), $urandom_range(0, 99) < density);
		cells_in_flight += n;
		phases_run++;
	endtask

	function automatic logic [wgns_pkg::THR_W-1:0] pick_threshold();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return wgns_pkg::THR_W'($urandom_range(9, 15));   // never reached
		if (pick < 30)
			return ($urandom_range(0, 1) != 0) ? wgns_pkg::THR_W'(8) : wgns_pkg::THR_W'(0);
		return wgns_pkg::THR_W'($urandom_range(0, 8));
	endfunction

	function automatic logic [wgns_pkg::SIZE_W-1:0] pick_size(input int max_small);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return wgns_pkg::SIZE_W'($urandom_range(0, 2));    // saturates up to 3
		return wgns_pkg::SIZE_W'($urandom_range(3, max_small));
	endfunction

	initial begin
		int random_cells;
		random_cells = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed: smallest grid all wall and all floor at reset thresholds
		run_phase(9'd3, 9'd3, wgns_pkg::RST_KEEP, wgns_pkg::RST_GROW, 100, -1, 1'b0);
		run_phase(9'd3, 9'd3, wgns_pkg::RST_KEEP, wgns_pkg::RST_GROW, 0, -1, 1'b0);

		// out-of-range sizes saturate to the maximum: part of the first row of a wide grid,
		// then the top rows of a tall one, closed by shrinking past both counters
		run_phase(9'd511, 9'd3, pick_threshold(), pick_threshold(), 50, 10, 1'b0);
		run_phase(9'd3, 9'd300, pick_threshold(), pick_threshold(), 50, 12, 1'b1);
		run_phase(9'd3, 9'd3, 4'd5, 4'd6, 50, -1, 1'b0);

		// shrink mid-grid past both counters: the next cell closes the frame
		run_phase(9'd6, 9'd5, 4'd5, 4'd6, 50, 23, 1'b0);
		run_phase(9'd4, 9'd3, 4'd5, 4'd6, 50, -1, 1'b0);
		// widen mid-grid and shorten by one row
		run_phase(9'd4, 9'd5, 4'd4, 4'd5, 50, 6, 1'b0);
		run_phase(9'd7, 9'd4, 4'd4, 4'd5, 50, -1, 1'b0);

		// random small grids with random thresholds and densities
		while (random_cells < RANDOM_CELLS) begin
			logic [wgns_pkg::SIZE_W-1:0] w_raw, h_raw;
			int                          w_sel;
			w_sel = $urandom_range(0, 99);
			w_raw = (w_sel < 10) ? wgns_pkg::SIZE_W'($urandom_range(9, 16)) : pick_size(8);
			h_raw = pick_size(6);
			run_phase(w_raw, h_raw, pick_threshold(), pick_threshold(),
				$urandom_range(10, 90), -1, $urandom_range(0, 3) == 0);
			random_cells += int'(clamp_size(w_raw, wgns_pkg::MAX_WIDTH)) *
				int'(clamp_size(h_raw, wgns_pkg::MAX_HEIGHT));
		end

		calm_phase = 1'b0;
		wait_idle();
		repeat (2 * SETTLE_CYCLES) @(negedge clk);

		$display("ran %0d grid phases: %0d cells in, %0d results checked, %0d mismatches",
			phases_run, cells_sent, results_seen, mismatches);
		$display("sizes 3..256 incl. saturated and mid-grid resizes, thresholds 0..15");
		if (expected_cells.size() != 0)
			$display("%0d expected results never arrived", expected_cells.size());
		if (mismatches == 0 && expected_cells.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d cells pending, %0d results expected",
			cells_in_flight, expected_cells.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
